FILE: rtl/modular_exponentiation_macros.svh
// Assertion macros for the modular exponentiation block.
// Included by the top level; depends on nothing else.
`ifndef MODULAR_EXPONENTIATION_MACROS_SVH
`define MODULAR_EXPONENTIATION_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MODEXP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define MODEXP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/modexp_pkg.sv
// Package for the modular exponentiation block: widths, constants and the
// controller/datapath command and status types. Depends on nothing.
`timescale 1ns / 1ps

package modexp_pkg;

    localparam int MOD_W      = 31;
    localparam int VAL_W      = 63;
    localparam int DIV_W      = 64;
    localparam int RED_BITS   = 4;
    localparam int STEPS      = DIV_W / RED_BITS;
    localparam int CNT_W      = $clog2(STEPS);
    localparam int PROD_W     = 2 * MOD_W;
    localparam int ADDR_W     = 3;
    localparam int IN_DATA_W  = 128;
    localparam int OUT_DATA_W = 32;
    localparam int APB_W      = 32;

    localparam logic [MOD_W-1:0] MODULUS_RESET = MOD_W'(1000000007);

    localparam logic REG_MODULUS = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RED_BASE,
        ST_BIT,
        ST_MUL_ACC,
        ST_RED_ACC,
        ST_MUL_SQ,
        ST_RED_SQ,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic load;
        logic mul;
        logic sel_acc;
        logic step;
        logic wr_acc;
        logic wr_sq;
        logic shift_e;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic last;
        logic e_zero;
        logic e_lsb;
    } t_status;

endpackage

FILE: rtl/modexp_dp.sv
// Datapath of the modular exponentiation block: operand registers, the
// 31x31 multiplier and the shared radix-16 restoring reduction unit.
// Depends on modexp_pkg.
`timescale 1ns / 1ps

module modexp_dp import modexp_pkg::*; (
    input  logic             i_clk,
    input  t_cmd             i_cmd,
    input  logic [VAL_W-1:0] i_base,
    input  logic [VAL_W-1:0] i_exponent,
    input  logic [MOD_W-1:0] i_modulus,
    output t_status          o_status,
    output logic [MOD_W-1:0] o_result
);

    logic [MOD_W-1:0]  r_m;
    logic [VAL_W-1:0]  r_e;
    logic [MOD_W-1:0]  r_acc;
    logic [MOD_W-1:0]  r_sq;
    logic [DIV_W-1:0]  r_div;
    logic [MOD_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_cnt;
    logic [MOD_W-1:0]  r_out;

    logic [MOD_W-1:0]  n_rem;
    logic [DIV_W-1:0]  n_div;
    logic [MOD_W:0]    w_trial;
    logic [MOD_W-1:0]  w_mul_a;
    logic [PROD_W-1:0] w_prod;

    // Shift four dividend bits into the partial remainder, one conditional
    // subtract of the modulus per bit.
    always_comb begin
        n_rem   = r_rem;
        n_div   = r_div;
        w_trial = '0;
        for (int i = 0; i < RED_BITS; i++) begin
            w_trial = {n_rem, n_div[DIV_W-1]};
            n_div   = {n_div[DIV_W-2:0], 1'b0};
            if (w_trial >= {1'b0, r_m}) begin
                w_trial = w_trial - {1'b0, r_m};
            end
            n_rem = w_trial[MOD_W-1:0];
        end
    end

    assign w_mul_a = i_cmd.sel_acc ? r_acc : r_sq;
    assign w_prod  = w_mul_a * r_sq;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_div <= {1'b0, i_base};
            r_e   <= i_exponent;
            r_m   <= (i_modulus == '0) ? MOD_W'(1) : i_modulus;
            r_acc <= MOD_W'(1);
            r_rem <= '0;
            r_cnt <= '0;
        end else if (i_cmd.mul) begin
            r_div <= {{(DIV_W-PROD_W){1'b0}}, w_prod};
            r_rem <= '0;
            r_cnt <= '0;
        end else if (i_cmd.step) begin
            r_div <= n_div;
            r_rem <= n_rem;
            r_cnt <= r_cnt + CNT_W'(1);
        end
        if (i_cmd.wr_acc) begin
            r_acc <= n_rem;
        end
        if (i_cmd.wr_sq) begin
            r_sq <= n_rem;
        end
        if (i_cmd.shift_e) begin
            r_e <= r_e >> 1;
        end
        if (i_cmd.out_load) begin
            r_out <= r_acc;
        end
    end

    assign o_status.last   = (r_cnt == CNT_W'(STEPS - 1));
    assign o_status.e_zero = (r_e == '0);
    assign o_status.e_lsb  = r_e[0];
    assign o_result        = r_out;

endmodule

FILE: rtl/modexp_ctrl.sv
// Controller of the modular exponentiation block: sequences base reduction
// and the square-and-multiply loop, and owns the stream handshakes.
// Depends on modexp_pkg.
`timescale 1ns / 1ps

module modexp_ctrl import modexp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_in_ready,
    output logic    o_out_valid
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_RED_BASE;
                end
            end
            ST_RED_BASE: begin
                o_cmd.step = 1'b1;
                if (i_status.last) begin
                    o_cmd.wr_sq = 1'b1;
                    n_state     = ST_BIT;
                end
            end
            ST_BIT: begin
                if (i_status.e_zero) begin
                    n_state = ST_FINISH;
                end else if (i_status.e_lsb) begin
                    n_state = ST_MUL_ACC;
                end else begin
                    n_state = ST_MUL_SQ;
                end
            end
            ST_MUL_ACC: begin
                o_cmd.mul     = 1'b1;
                o_cmd.sel_acc = 1'b1;
                n_state       = ST_RED_ACC;
            end
            ST_RED_ACC: begin
                o_cmd.step = 1'b1;
                if (i_status.last) begin
                    o_cmd.wr_acc = 1'b1;
                    n_state      = ST_MUL_SQ;
                end
            end
            ST_MUL_SQ: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_RED_SQ;
            end
            ST_RED_SQ: begin
                o_cmd.step = 1'b1;
                if (i_status.last) begin
                    o_cmd.wr_sq   = 1'b1;
                    o_cmd.shift_e = 1'b1;
                    n_state       = ST_BIT;
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

FILE: rtl/modular_exponentiation.sv
// One item at a time: the next input transfer is taken only once the last item has passed
// through base reduction and the square-and-multiply loop and its result has been loaded
// into the result register; the shared reduction unit works four bits a cycle. The result
// register lets a new input transfer start while the last result waits.
// Synchronous active-low reset idles the block, drops m_tvalid and sets modulus to 1000000007.
`timescale 1ns / 1ps
`include "modular_exponentiation_macros.svh"

module modular_exponentiation import modexp_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // base_value[62:0], exponent[125:63], zero pad
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // power_result[30:0], zero pad
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [APB_W-1:0]      pwdata,
    output logic [APB_W-1:0]      prdata,
    output logic                  pready
);

    logic [MOD_W-1:0] r_modulus;
    logic             w_reg_idx;
    logic             w_in_xfer;
    t_cmd             w_cmd;
    t_status          w_status;
    logic [MOD_W-1:0] w_result;

    assign pready    = 1'b1;
    assign w_reg_idx = paddr[ADDR_W-1];
    assign w_in_xfer = s_tvalid && s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= MODULUS_RESET;
        end else if (psel && penable && pwrite && pready && (w_reg_idx == REG_MODULUS)) begin
            r_modulus <= pwdata[MOD_W-1:0];
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            REG_MODULUS: prdata = {{(APB_W-MOD_W){1'b0}}, r_modulus};
            default:     prdata = '0;
        endcase
    end

    modexp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_tvalid),
        .i_out_ready (m_tready),
        .i_status    (w_status),
        .o_cmd       (w_cmd),
        .o_in_ready  (s_tready),
        .o_out_valid (m_tvalid)
    );

    modexp_dp u_dp (
        .i_clk      (i_clk),
        .i_cmd      (w_cmd),
        .i_base     (s_tdata[VAL_W-1:0]),
        .i_exponent (s_tdata[2*VAL_W-1:VAL_W]),
        .i_modulus  (r_modulus),
        .o_status   (w_status),
        .o_result   (w_result)
    );

    assign m_tdata = {{(OUT_DATA_W-MOD_W){1'b0}}, w_result};

    `MODEXP_ASSERT_NEXT(a_busy, i_clk, i_rst_n, w_in_xfer, !s_tready, "transfer while busy")
    `MODEXP_ASSERT_NOW(a_rise, i_clk, i_rst_n, $rose(m_tvalid), !$past(s_tready), "stray result")
    `MODEXP_ASSERT_NEXT(a_fast, i_clk, i_rst_n, w_in_xfer && !m_tvalid, !m_tvalid, "fast result")

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for modular_exponentiation: streams base/exponent pairs over
// the stream ports under several moduli set through the APB port. Uses modexp_pkg for
// widths and register addresses; the expected powers come from its own square-and-multiply.
`timescale 1ns / 1ps

module testbench;
    import modexp_pkg::*;

    localparam int          PHASE_ITEMS = 120;
    localparam int          DRAIN_WAIT  = 2400;
    localparam longint      LIMIT       = 20_000_000;
    localparam logic [62:0] MAX_VAL     = {VAL_W{1'b1}};

    typedef struct {
        logic [VAL_W-1:0] base_value;
        logic [VAL_W-1:0] exponent;
    } t_job;

    typedef struct {
        logic [VAL_W-1:0] base_value;
        logic [VAL_W-1:0] exponent;
        logic [MOD_W-1:0] modulus;
        logic [MOD_W-1:0] power;
    } t_expected;

    logic                  i_clk    = 1'b0;
    logic                  i_rst_n  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;  // base_value, exponent, zero pad
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;        // power_result, zero pad
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [ADDR_W-1:0]     paddr    = '0;
    logic [APB_W-1:0]      pwdata   = '0;
    logic [APB_W-1:0]      prdata;
    logic                  pready;

    t_job             pending_jobs[$];
    t_expected        expected_powers[$];
    logic [MOD_W-1:0] modulus_shadow = MODULUS_RESET;
    int               error_count    = 0;
    longint           cycle_count    = 0;
    int               burst_left     = 0;
    int               gap_left       = 0;
    int               stall_level    = 0;
    t_job             next_job;
    t_expected        arrived;

    modular_exponentiation u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [MOD_W-1:0] mod_power(input logic [VAL_W-1:0] base_value,
                                                   input logic [VAL_W-1:0] exponent,
                                                   input logic [MOD_W-1:0] modulus);
        logic [63:0]      m;
        logic [63:0]      square;
        logic [63:0]      acc;
        logic [VAL_W-1:0] bits;
        m      = (modulus == '0) ? 64'd1 : 64'(modulus);
        square = 64'(base_value) % m;
        acc    = 64'd1;
        bits   = exponent;
        while (bits != '0) begin
            if (bits[0]) begin
                acc = (acc * square) % m;
            end
            square = (square * square) % m;
            bits   = bits >> 1;
        end
        return acc[MOD_W-1:0];
    endfunction

    function automatic logic [VAL_W-1:0] rand_val();
        return VAL_W'({$urandom, $urandom});
    endfunction

    task automatic report_mismatch(input string what);
        $display("ERROR @%0t: %s", $realtime, what);
        error_count++;
    endtask

    task automatic add_job(input logic [VAL_W-1:0] base_value, input logic [VAL_W-1:0] exponent);
        t_job job;
        job.base_value = base_value;
        job.exponent   = exponent;
        pending_jobs.insert(pending_jobs.size(), job);
    endtask

    task automatic wait_drained();
        do begin
            @(posedge i_clk);
        end while (pending_jobs.size() != 0 || s_tvalid || expected_powers.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_access(input logic is_write, input logic [APB_W-1:0] wdata,
                              output logic [APB_W-1:0] rdata);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= ADDR_W'(4 * int'(REG_MODULUS));
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        rdata   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (is_write) begin
            modulus_shadow = wdata[MOD_W-1:0];
        end
    endtask

    task automatic check_modulus_reg();
        logic [APB_W-1:0] rdata;
        apb_access(1'b0, '0, rdata);
        if (rdata !== APB_W'(modulus_shadow)) begin
            report_mismatch($sformatf("modulus reads %0d, expected %0d", rdata, modulus_shadow));
        end
    endtask

    task automatic set_modulus(input logic [APB_W-1:0] value);
        logic [APB_W-1:0] rdata;
        apb_access(1'b1, value, rdata);
        check_modulus_reg();
    endtask

    task automatic queue_phase();
        logic [63:0]      m;
        logic [VAL_W-1:0] base_value;
        logic [VAL_W-1:0] exponent;
        m = (modulus_shadow == '0) ? 64'd1 : 64'(modulus_shadow);
        add_job('0, '0);
        add_job(rand_val(), '0);
        add_job(VAL_W'(m * $urandom_range(1, 50)), VAL_W'($urandom_range(1, 40)));
        add_job(VAL_W'(m - 1), 2);
        add_job(MAX_VAL, MAX_VAL);
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            case ($urandom_range(0, 7))
                0:       base_value = VAL_W'($urandom_range(0, 20));
                1:       base_value = VAL_W'(m * $urandom_range(1, 1000) + $urandom_range(0, 2) - 1);
                default: base_value = rand_val();
            endcase
            case ($urandom_range(0, 9))
                0:       exponent = VAL_W'($urandom_range(0, 3));
                7, 8:    exponent = VAL_W'($urandom);
                9:       exponent = rand_val();
                default: exponent = VAL_W'($urandom_range(0, 4095));
            endcase
            add_job(base_value, exponent);
        end
    endtask

    // Sender: bursts of random length separated by random gaps, some of them long.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                arrived.base_value = s_tdata[VAL_W-1:0];
                arrived.exponent   = s_tdata[2*VAL_W-1:VAL_W];
                arrived.modulus    = modulus_shadow;
                arrived.power      = mod_power(arrived.base_value, arrived.exponent,
                                               modulus_shadow);
                expected_powers.insert(expected_powers.size(), arrived);
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (pending_jobs.size() > 0) begin
                    next_job = pending_jobs.pop_front();
                    s_tdata  <= {2'b00, next_job.exponent, next_job.base_value};
                    s_tvalid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 12);
                        case ($urandom_range(0, 5))
                            0, 1:    gap_left = 0;
                            2:       gap_left = $urandom_range(100, 600);
                            default: gap_left = $urandom_range(1, 40);
                        endcase
                    end else begin
                        burst_left--;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stall density is redrawn at random from four levels, including stretches with none.
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            if (expected_powers.size() == 0) begin
                report_mismatch($sformatf("unexpected result %0d", m_tdata[MOD_W-1:0]));
            end else begin
                arrived = expected_powers.pop_front();
                if (m_tdata[MOD_W-1:0] !== arrived.power) begin
                    report_mismatch($sformatf("%0d ^ %0d mod %0d: got %0d, expected %0d",
                                              arrived.base_value, arrived.exponent,
                                              arrived.modulus, m_tdata[MOD_W-1:0],
                                              arrived.power));
                end
            end
        end
        if (cycle_count % 2048 == 0) begin
            stall_level = $urandom_range(0, 3);
        end
        case (stall_level)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 99) >= 25);
            2:       m_tready <= ($urandom_range(0, 99) >= 60);
            default: m_tready <= ($urandom_range(0, 99) >= 90);
        endcase
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        logic [APB_W-1:0] moduli[10];
        moduli = '{32'd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'd2, 32'd3, 32'd65537,
                   32'd1000000007, 32'hFFFF_FFFF, $urandom, $urandom | 32'h4000_0000};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        check_modulus_reg();

        // Field extremes and Fermat-style cases under the reset modulus.
        add_job('0, 1);
        add_job(1, '0);
        add_job(MAX_VAL, 1);
        add_job('0, MAX_VAL);
        add_job(1, MAX_VAL);
        add_job(2, 62);
        add_job(2, 63);
        add_job(VAL_W'(MODULUS_RESET), 5);
        add_job(VAL_W'(MODULUS_RESET) - 1, 3);
        add_job(VAL_W'(MODULUS_RESET) + 1, MAX_VAL);
        add_job(3, VAL_W'(1) << 62);
        add_job(VAL_W'(1) << 62, 3);
        add_job(123456789, VAL_W'(MODULUS_RESET) - 2);
        add_job(MAX_VAL, VAL_W'(MODULUS_RESET) - 1);
        add_job(VAL_W'({32'hAAAA_AAAA, 32'hAAAA_AAAA}), VAL_W'({32'h5555_5555, 32'h5555_5555}));
        add_job(VAL_W'({32'h5555_5555, 32'h5555_5555}), VAL_W'({32'h2AAA_AAAA, 32'hAAAA_AAAA}));
        queue_phase();
        wait_drained();

        foreach (moduli[k]) begin
            set_modulus(moduli[k]);
            queue_phase();
            wait_drained();
        end

        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
